/* design/websocket_frame_echo_defines.svh */
// Assertion macros shared by the frame echo modules.
// Each macro expects clk and rst to be in scope in the module that uses it.
`ifndef WEBSOCKET_FRAME_ECHO_DEFINES_SVH
`define WEBSOCKET_FRAME_ECHO_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WFE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define WFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define WFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wfe_pkg.sv */
// Types and constants shared by the WebSocket frame echo modules.
// No dependencies.
package wfe_pkg;

  localparam int LenW = 25;

  localparam logic [LenW-1:0] MAX_LEN_RESET = 25'd16777216;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;
  localparam logic [3:0] OP_DATA_MAX = 4'h2;

  // What one received byte causes at the output.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PAYLOAD,
    KIND_HEADER,
    KIND_ERROR
  } kind_t;

  // Result descriptor handed from the parser to the emitter.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       byte0;   // payload byte, or first header byte
    logic [LenW-1:0]  len;     // payload length for a header
    logic             fe;      // frame ends on the final result
    logic             cl;      // close on the final result
  } desc_t;

endpackage

/* design/wfe_parser.sv */
// Byte-serial frame header parser, unmasking and result descriptor generation.
// Depends on wfe_pkg and websocket_frame_echo_defines.svh.
`include "websocket_frame_echo_defines.svh"

module wfe_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 in_byte,
  input  logic                       new_connection,
  input  logic                       cfg_we,
  input  logic [wfe_pkg::LenW-1:0]   cfg_wdata,
  output logic                       desc_valid,
  output wfe_pkg::desc_t             desc
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    ACT_DROP,
    ACT_DATA,
    ACT_PONG,
    ACT_CLOSE
  } action_t;

  phase_t                     phase, phase_next, c_phase;
  action_t                    action, action_next, c_action;
  logic                       fin, fin_next, c_fin;
  logic [3:0]                 opcode, opcode_next, c_opcode;
  logic                       masked, masked_next, c_masked;
  logic [wfe_pkg::LenW-1:0]   acc, acc_next, c_acc;
  logic                       ovf, ovf_next, c_ovf;
  logic [2:0]                 cnt, cnt_next, c_cnt;
  logic [31:0]                key, key_next, c_key;
  logic [wfe_pkg::LenW-1:0]   left, left_next, c_left;
  logic [1:0]                 pos, pos_next, c_pos;
  logic [wfe_pkg::LenW-1:0]   max_len;
  logic                       len_done, fin_hdr;
  logic [7:0]                 key_byte;

  always_comb begin
    // A new connection clears the parser before this byte is handled.
    c_phase  = new_connection ? PH_HDR0 : phase;
    c_action = new_connection ? ACT_DROP : action;
    c_fin    = new_connection ? 1'b0 : fin;
    c_opcode = new_connection ? 4'd0 : opcode;
    c_masked = new_connection ? 1'b0 : masked;
    c_acc    = new_connection ? '0 : acc;
    c_ovf    = new_connection ? 1'b0 : ovf;
    c_cnt    = new_connection ? 3'd0 : cnt;
    c_key    = new_connection ? 32'd0 : key;
    c_left   = new_connection ? '0 : left;
    c_pos    = new_connection ? 2'd0 : pos;

    phase_next  = c_phase;
    action_next = c_action;
    fin_next    = c_fin;
    opcode_next = c_opcode;
    masked_next = c_masked;
    acc_next    = c_acc;
    ovf_next    = c_ovf;
    cnt_next    = c_cnt;
    key_next    = c_key;
    left_next   = c_left;
    pos_next    = c_pos;

    len_done = 1'b0;
    fin_hdr  = 1'b0;
    desc     = '{kind: wfe_pkg::KIND_NONE, byte0: 8'd0, len: '0, fe: 1'b0, cl: 1'b0};

    case (c_pos)
      2'd0:    key_byte = c_key[31:24];
      2'd1:    key_byte = c_key[23:16];
      2'd2:    key_byte = c_key[15:8];
      default: key_byte = c_key[7:0];
    endcase

    case (c_phase)
      PH_HDR0: begin
        fin_next    = in_byte[7];
        opcode_next = in_byte[3:0];
        if (in_byte[3:0] <= wfe_pkg::OP_DATA_MAX) begin
          action_next = ACT_DATA;
        end else if (in_byte[3:0] == wfe_pkg::OP_PING) begin
          action_next = ACT_PONG;
        end else if (in_byte[3:0] == wfe_pkg::OPCODE_CLOSE) begin
          action_next = ACT_CLOSE;
        end else begin
          action_next = ACT_DROP;
        end
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        masked_next = in_byte[7];
        acc_next    = '0;
        ovf_next    = 1'b0;
        if (in_byte[6:0] == wfe_pkg::LEN_CODE_16) begin
          cnt_next   = 3'd1;
          phase_next = PH_EXTLEN;
        end else if (in_byte[6:0] == wfe_pkg::LEN_CODE_64) begin
          cnt_next   = 3'd7;
          phase_next = PH_EXTLEN;
        end else begin
          acc_next = wfe_pkg::LenW'(in_byte[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // Only the low bits are kept; anything shifted out above them
        // makes the length too large for any limit.
        acc_next = {c_acc[wfe_pkg::LenW-9:0], in_byte};
        ovf_next = c_ovf | (|c_acc[wfe_pkg::LenW-1:wfe_pkg::LenW-8]);
        if (c_cnt == 3'd0) begin
          len_done = 1'b1;
        end else begin
          cnt_next = c_cnt - 3'd1;
        end
      end
      PH_MASK: begin
        key_next = {c_key[23:0], in_byte};
        if (c_cnt == 3'd0) begin
          fin_hdr = 1'b1;
        end else begin
          cnt_next = c_cnt - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        left_next = c_left - wfe_pkg::LenW'(1);
        pos_next  = c_pos + 2'd1;
        if (c_action != ACT_DROP) begin
          desc.kind  = wfe_pkg::KIND_PAYLOAD;
          desc.byte0 = in_byte ^ key_byte;
          desc.fe    = (left_next == '0);
          desc.cl    = (left_next == '0) && (c_action == ACT_CLOSE);
        end
        if (left_next == '0) begin
          phase_next = (c_action == ACT_CLOSE) ? PH_STOPPED : PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_STOPPED;
      end
    endcase

    if (len_done) begin
      if (ovf_next || (acc_next > max_len)) begin
        phase_next = PH_STOPPED;
        desc.kind  = wfe_pkg::KIND_ERROR;
        desc.cl    = 1'b1;
      end else begin
        left_next = acc_next;
        key_next  = 32'd0;
        if (masked_next) begin
          cnt_next   = 3'd3;
          phase_next = PH_MASK;
        end else begin
          fin_hdr = 1'b1;
        end
      end
    end

    if (fin_hdr) begin
      if (action_next != ACT_DROP) begin
        desc.kind = wfe_pkg::KIND_HEADER;
        case (action_next)
          ACT_DATA:  desc.byte0 = {fin_next, 3'b000, opcode_next};
          ACT_PONG:  desc.byte0 = {1'b1, 3'b000, wfe_pkg::OP_PONG};
          default:   desc.byte0 = {1'b1, 3'b000, wfe_pkg::OPCODE_CLOSE};
        endcase
        desc.len = left_next;
        desc.fe  = (left_next == '0);
        desc.cl  = (left_next == '0) && (action_next == ACT_CLOSE);
      end
      if (left_next == '0) begin
        phase_next = (action_next == ACT_CLOSE) ? PH_STOPPED : PH_HDR0;
      end else begin
        pos_next   = 2'd0;
        phase_next = PH_PAYLOAD;
      end
    end
  end

  assign desc_valid = (desc.kind != wfe_pkg::KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= wfe_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      action <= ACT_DROP;
      fin    <= 1'b0;
      opcode <= 4'd0;
      masked <= 1'b0;
      acc    <= '0;
      ovf    <= 1'b0;
      cnt    <= 3'd0;
      key    <= 32'd0;
      left   <= '0;
      pos    <= 2'd0;
    end else if (accept) begin
      phase  <= phase_next;
      action <= action_next;
      fin    <= fin_next;
      opcode <= opcode_next;
      masked <= masked_next;
      acc    <= acc_next;
      ovf    <= ovf_next;
      cnt    <= cnt_next;
      key    <= key_next;
      left   <= left_next;
      pos    <= pos_next;
    end
  end

  `WFE_ASSERT_NEXT(a_stopped_holds, (phase == PH_STOPPED) && !(accept && new_connection), phase == PH_STOPPED, "stopped stream resumed without a new connection")
  `WFE_ASSERT_NEXT(a_error_stops, accept && (desc.kind == wfe_pkg::KIND_ERROR), phase == PH_STOPPED, "protocol error did not stop the stream")

endmodule

/* design/wfe_emitter.sv */
// Holds one result descriptor and serialises it into output transfers
// through a registered output stage. Depends on wfe_pkg and the defines header.
`include "websocket_frame_echo_defines.svh"

module wfe_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  wfe_pkg::desc_t  desc_in,
  output logic            desc_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            frame_end,
  output logic            close_now,
  output logic            protocol_error,
  output logic            last
);

  wfe_pkg::desc_t  desc;
  logic            d_valid;
  logic [3:0]      idx;
  logic [3:0]      count;
  logic            len_short, len_mid;
  logic            advance, take, final_idx;
  logic [7:0]      cur_byte;

  assign len_short = (desc.len < wfe_pkg::LenW'(wfe_pkg::LEN_CODE_16));
  assign len_mid   = (desc.len[wfe_pkg::LenW-1:16] == '0);

  always_comb begin
    if (desc.kind != wfe_pkg::KIND_HEADER) begin
      count = 4'd1;
    end else if (len_short) begin
      count = 4'd2;
    end else if (len_mid) begin
      count = 4'd4;
    end else begin
      count = 4'd10;
    end
  end

  // Header bytes: first byte, length code, then the big-endian length.
  always_comb begin
    cur_byte = 8'd0;
    if ((desc.kind != wfe_pkg::KIND_HEADER) || (idx == 4'd0)) begin
      cur_byte = desc.byte0;
    end else if (len_short) begin
      cur_byte = {1'b0, desc.len[6:0]};
    end else if (len_mid) begin
      case (idx)
        4'd1:    cur_byte = {1'b0, wfe_pkg::LEN_CODE_16};
        4'd2:    cur_byte = desc.len[15:8];
        default: cur_byte = desc.len[7:0];
      endcase
    end else begin
      case (idx)
        4'd1:    cur_byte = {1'b0, wfe_pkg::LEN_CODE_64};
        4'd6:    cur_byte = {7'd0, desc.len[24]};
        4'd7:    cur_byte = desc.len[23:16];
        4'd8:    cur_byte = desc.len[15:8];
        4'd9:    cur_byte = desc.len[7:0];
        default: cur_byte = 8'd0;
      endcase
    end
  end

  assign advance    = !out_valid || !out_stall;
  assign take       = d_valid && advance;
  assign final_idx  = (idx == (count - 4'd1));
  assign desc_ready = !d_valid || (advance && final_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= d_valid;
      end
      if (take) begin
        idx <= final_idx ? 4'd0 : idx + 4'd1;
      end
      if (load) begin
        d_valid <= 1'b1;
      end else if (take && final_idx) begin
        d_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte       <= cur_byte;
      has_byte       <= (desc.kind != wfe_pkg::KIND_ERROR);
      frame_end      <= final_idx && desc.fe;
      close_now      <= final_idx && desc.cl;
      protocol_error <= (desc.kind == wfe_pkg::KIND_ERROR);
      last           <= final_idx;
    end
  end

  `WFE_ASSERT_SAME(a_idx_range, d_valid, idx < count, "result index ran past the descriptor")
  `WFE_ASSERT_ALWAYS(a_idx_idle, d_valid || (idx == 4'd0), "result index not cleared when idle")
  `WFE_ASSERT_SAME(a_error_shape, out_valid && protocol_error, !has_byte && close_now && last, "error result has the wrong flags")

endmodule

/* design/websocket_frame_echo.sv */
// Top level of the WebSocket frame echo: parser feeding a result emitter.
// Depends on wfe_pkg, wfe_parser and wfe_emitter.
//
//  Channel  Handshake          Payload
//  -------  -----------------  ------------------------------------------------
//  input    in_valid/in_stall  in_byte, new_connection
//  output   out_valid/out_stall out_byte, has_byte, frame_end, close_now,
//                              protocol_error, last
//  config   cfg_we             cfg_wdata (max_payload_len)
//
// One received byte is taken per cycle while no multi-byte header is pending and
// the output is not stalled; payload bytes pass the descriptor and output
// registers at one transfer per unstalled cycle. A completed inbound header
// yields 2, 4 or 10 transfers the same way, and input is stalled until the last.
// Reset (rst, synchronous) clears the parser and sets the length limit to 16 MiB.
// Output stall holds the output register and, through the emitter, the input.

module websocket_frame_echo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      new_connection,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      has_byte,
  output logic                      frame_end,
  output logic                      close_now,
  output logic                      protocol_error,
  output logic                      last,
  input  logic                      cfg_we,
  input  logic [wfe_pkg::LenW-1:0]  cfg_wdata
);

  logic            accept;
  logic            desc_valid;
  logic            desc_ready;
  wfe_pkg::desc_t  desc;

  assign in_stall = !desc_ready;
  assign accept   = in_valid && !in_stall;

  wfe_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .new_connection (new_connection),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .desc_valid     (desc_valid),
    .desc           (desc)
  );

  wfe_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .load           (accept && desc_valid),
    .desc_in        (desc),
    .desc_ready     (desc_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .frame_end      (frame_end),
    .close_now      (close_now),
    .protocol_error (protocol_error),
    .last           (last)
  );

endmodule

/* tb/websocket_frame_echo_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_echo: directed frames, then random frame traffic.
// Every output transfer is checked against a built-in parser and echo predictor.
// Depends on wfe_pkg and the websocket_frame_echo RTL.
module websocket_frame_echo_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [2:0] {
    RX_HDR0,
    RX_HDR1,
    RX_EXTLEN,
    RX_MASK,
    RX_PAYLOAD,
    RX_STOPPED
  } rx_phase_t;

  typedef enum logic [1:0] {
    ECHO_DROP,
    ECHO_DATA,
    ECHO_PONG,
    ECHO_CLOSE
  } echo_act_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fend;
    logic       cls;
    logic       perr;
    logic       lst;
  } echo_beat_t;

  typedef logic [7:0] byte_q_t[$];

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_byte = 8'h00;
  logic                     new_connection = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               out_byte;
  logic                     has_byte;
  logic                     frame_end;
  logic                     close_now;
  logic                     protocol_error;
  logic                     last;
  logic                     cfg_we = 1'b0;
  logic [wfe_pkg::LenW-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  websocket_frame_echo DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .new_connection (new_connection),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .frame_end      (frame_end),
    .close_now      (close_now),
    .protocol_error (protocol_error),
    .last           (last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // Predictor state: a shadow of the frame parser and its length limit.
  logic [wfe_pkg::LenW-1:0] lim = wfe_pkg::MAX_LEN_RESET;
  rx_phase_t                ph = RX_HDR0;
  logic                     fin_q = 1'b0;
  logic [3:0]               opc = 4'h0;
  logic                     msk = 1'b0;
  logic [63:0]              acc = '0;
  logic [2:0]               cnt = '0;
  logic [31:0]              key = '0;
  logic [wfe_pkg::LenW-1:0] left = '0;
  logic [1:0]               mpos = '0;
  echo_act_t                act = ECHO_DROP;

  echo_beat_t step_beats[$];
  echo_beat_t pending_echo[$];
  echo_beat_t got_beat;
  echo_beat_t want_beat;

  int unsigned fails = 0;
  int unsigned checked = 0;
  int unsigned items_sent = 0;
  int unsigned live_items = 0;
  int unsigned limit_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        next_nc = 1'b0;

  task automatic clear_parser();
    ph = RX_HDR0;
    fin_q = 1'b0;
    opc = 4'h0;
    msk = 1'b0;
    acc = '0;
    cnt = '0;
    key = '0;
    left = '0;
    mpos = '0;
    act = ECHO_DROP;
  endtask

  task automatic put_beat(input logic [7:0] d, input logic h, input logic cl, input logic pe);
    echo_beat_t bt;
    bt = '{data: d, has: h, fend: 1'b0, cls: cl, perr: pe, lst: 1'b0};
    step_beats.push_back(bt);
  endtask

  // The frame is over: flag the last echoed byte and choose where parsing resumes.
  task automatic close_frame();
    echo_beat_t bt;
    if (act != ECHO_DROP && step_beats.size() > 0) begin
      bt = step_beats.pop_back();
      bt.fend = 1'b1;
      if (act == ECHO_CLOSE) bt.cls = 1'b1;
      step_beats.push_back(bt);
    end
    ph = (act == ECHO_CLOSE) ? RX_STOPPED : RX_HDR0;
  endtask

  task automatic emit_header();
    logic [7:0]  b0;
    logic [63:0] wide;
    if (act != ECHO_DROP) begin
      case (act)
        ECHO_DATA: b0 = {fin_q, 3'b000, opc};
        ECHO_PONG: b0 = {1'b1, 3'b000, wfe_pkg::OP_PONG};
        default:   b0 = {1'b1, 3'b000, wfe_pkg::OPCODE_CLOSE};
      endcase
      put_beat(b0, 1'b1, 1'b0, 1'b0);
      if (left < 126) begin
        put_beat(left[7:0], 1'b1, 1'b0, 1'b0);
      end else if (left <= 25'h000FFFF) begin
        put_beat({1'b0, wfe_pkg::LEN_CODE_16}, 1'b1, 1'b0, 1'b0);
        put_beat(left[15:8], 1'b1, 1'b0, 1'b0);
        put_beat(left[7:0], 1'b1, 1'b0, 1'b0);
      end else begin
        put_beat({1'b0, wfe_pkg::LEN_CODE_64}, 1'b1, 1'b0, 1'b0);
        wide = 64'(left);
        for (int i = 0; i < 8; i++) put_beat(wide[63-8*i -: 8], 1'b1, 1'b0, 1'b0);
      end
    end
    if (left == 0) begin
      close_frame();
    end else begin
      mpos = '0;
      ph = RX_PAYLOAD;
    end
  endtask

  task automatic length_complete();
    if (acc > {39'd0, lim}) begin
      ph = RX_STOPPED;
      put_beat(8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      left = acc[wfe_pkg::LenW-1:0];
      key = '0;
      if (msk) begin
        cnt = 3'd3;
        ph = RX_MASK;
      end else begin
        emit_header();
      end
    end
  endtask

  // Works out the output transfers that one accepted byte causes.
  task automatic parse_and_echo(input logic [7:0] b, input logic nc);
    echo_beat_t bt;
    logic [6:0] l7;
    step_beats.delete();
    if (nc) clear_parser();
    case (ph)
      RX_HDR0: begin
        fin_q = b[7];
        opc = b[3:0];
        if (opc <= wfe_pkg::OP_DATA_MAX) act = ECHO_DATA;
        else if (opc == wfe_pkg::OP_PING) act = ECHO_PONG;
        else if (opc == wfe_pkg::OPCODE_CLOSE) act = ECHO_CLOSE;
        else act = ECHO_DROP;
        ph = RX_HDR1;
      end
      RX_HDR1: begin
        l7 = b[6:0];
        msk = b[7];
        acc = '0;
        if (l7 == wfe_pkg::LEN_CODE_16) begin
          cnt = 3'd1;
          ph = RX_EXTLEN;
        end else if (l7 == wfe_pkg::LEN_CODE_64) begin
          cnt = 3'd7;
          ph = RX_EXTLEN;
        end else begin
          acc = 64'(l7);
          length_complete();
        end
      end
      RX_EXTLEN: begin
        acc = {acc[55:0], b};
        if (cnt == 0) length_complete();
        else cnt = cnt - 3'd1;
      end
      RX_MASK: begin
        key = {key[23:0], b};
        if (cnt == 0) emit_header();
        else cnt = cnt - 3'd1;
      end
      RX_PAYLOAD: begin
        if (act != ECHO_DROP) put_beat(b ^ key[8*(3-mpos) +: 8], 1'b1, 1'b0, 1'b0);
        left = left - 1'b1;
        mpos = mpos + 2'd1;
        if (left == 0) close_frame();
      end
      default: ph = RX_STOPPED;
    endcase
    if (step_beats.size() > 0) begin
      bt = step_beats.pop_back();
      bt.lst = 1'b1;
      step_beats.push_back(bt);
    end
    while (step_beats.size() > 0) pending_echo.push_back(step_beats.pop_front());
  endtask

  function automatic string beat_str(input echo_beat_t b);
    return $sformatf("byte=%02h has=%0b end=%0b close=%0b err=%0b last=%0b",
                     b.data, b.has, b.fend, b.cls, b.perr, b.lst);
  endfunction

  task automatic log_failure(input string msg);
    fails++;
    if (fails <= 10) $display("ERROR: %s", msg);
  endtask

  // Called at a rising edge; returns at the edge where the transfer happens. The caller must
  // send the next byte or lower in_valid in that same step, so nothing is taken twice.
  task automatic send_byte(input logic [7:0] b, input logic nc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    new_connection <= nc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (nc || ph != RX_STOPPED) live_items++;
    items_sent++;
    parse_and_echo(b, nc);
  endtask

  task automatic send_seq(input byte_q_t seq, input logic nc_first);
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], (i == 0) ? nc_first : 1'b0);
  endtask

  // Lets every expected transfer arrive, then waits out the settle time for work with no output.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_echo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [wfe_pkg::LenW-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim = v;
    limit_writes++;
  endtask

  // One frame with random opcode, length form, mask and payload; sometimes cut short,
  // sometimes replaced by a burst of raw noise. A stopped or cut stream restarts.
  task automatic send_random_frame();
    byte_q_t     fb;
    logic [63:0] dlen;
    logic [31:0] mkey;
    logic [3:0]  op;
    logic [6:0]  code;
    logic        masked;
    logic        first;
    logic        cut;
    int unsigned r;
    int unsigned npay;
    int unsigned cap;
    fb.delete();
    first = next_nc;
    next_nc = 1'b0;
    r = $urandom_range(99);
    if (r < 6) begin
      cap = $urandom_range(1, 4);
      for (int i = 0; i < cap; i++) send_byte(8'($urandom), (i == 0) ? first : 1'b0);
      next_nc = 1'b1;
      return;
    end
    r = $urandom_range(99);
    if (r < 55) op = 4'($urandom_range(0, 2));
    else if (r < 70) op = wfe_pkg::OP_PING;
    else if (r < 80) op = wfe_pkg::OPCODE_CLOSE;
    else if (r < 88) op = wfe_pkg::OP_PONG;
    else if (r[0]) op = 4'($urandom_range(3, 7));
    else op = 4'($urandom_range(11, 15));
    fb.push_back({1'($urandom), 3'($urandom), op});
    masked = ($urandom_range(99) < 60);
    r = $urandom_range(99);
    if (r < 70) begin
      dlen = ($urandom_range(9) == 0) ? 64'($urandom_range(100, 125))
                                      : 64'($urandom_range(0, 12));
      code = dlen[6:0];
    end else if (r < 85) begin
      case ($urandom_range(2))
        0:       dlen = 64'($urandom_range(0, 12));
        1:       dlen = 64'($urandom_range(126, 400));
        default: dlen = 64'($urandom_range(0, 16'hFFFF));
      endcase
      code = wfe_pkg::LEN_CODE_16;
    end else begin
      case ($urandom_range(4))
        0:       dlen = 64'($urandom_range(0, 12));
        1:       dlen = 64'($urandom_range(0, 25'h1FFFFFF));
        2:       dlen = 64'(lim);
        3:       dlen = 64'(lim) + 64'd1;
        default: dlen = {$urandom, $urandom};
      endcase
      code = wfe_pkg::LEN_CODE_64;
    end
    fb.push_back({masked, code});
    if (code == wfe_pkg::LEN_CODE_16) begin
      fb.push_back(dlen[15:8]);
      fb.push_back(dlen[7:0]);
    end else if (code == wfe_pkg::LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) fb.push_back(dlen[8*i +: 8]);
    end
    mkey = $urandom;
    if (masked) for (int i = 3; i >= 0; i--) fb.push_back(mkey[8*i +: 8]);
    cut = (dlen > 130) || ($urandom_range(9) == 0);
    cap = (dlen < 16) ? int'(dlen) : 16;
    npay = cut ? $urandom_range(0, cap) : int'(dlen);
    for (int i = 0; i < npay; i++) fb.push_back(8'($urandom));
    for (int i = 0; i < fb.size(); i++) begin
      send_byte(fb[i], (i == 0) ? first : 1'b0);
      if (ph == RX_STOPPED) break;
    end
    if (ph == RX_STOPPED) begin
      cap = $urandom_range(0, 2);
      for (int i = 0; i < cap; i++) send_byte(8'($urandom), 1'b0);
      next_nc = 1'b1;
    end else if (cut) begin
      next_nc = 1'b1;
    end
  endtask

  task automatic test_masked_text();
    send_seq({8'h81, 8'h82, 8'h37, 8'hFA, 8'h21, 8'h3D, 8'h7F, 8'h9F}, 1'b0);
  endtask

  // Ping comes back as an empty pong; pong and a reserved opcode are swallowed.
  task automatic test_control_frames();
    send_seq({8'h89, 8'h00, 8'h8A, 8'h00, 8'h83, 8'h01, 8'hCC}, 1'b0);
  endtask

  // A 16-bit length field holding a short length is echoed in the 7-bit form.
  task automatic test_short_ext16();
    send_seq({8'h02, 8'h7E, 8'h00, 8'h01, 8'hA5}, 1'b0);
  endtask

  // A 64-bit length equal to the reset limit; the frame is then cut off.
  task automatic test_ext64_at_limit();
    set_limit(wfe_pkg::MAX_LEN_RESET);
    send_seq({8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
              8'h00, 8'hFF}, 1'b0);
  endtask

  // An empty close frame is echoed and the byte after it is ignored.
  task automatic test_close_stops();
    send_seq({8'h88, 8'h00, 8'hFF}, 1'b1);
  endtask

  // With a zero limit an empty frame still passes but a one-byte frame is an error.
  task automatic test_length_limit();
    set_limit('0);
    send_seq({8'h82, 8'h00, 8'h82, 8'h01}, 1'b1);
    next_nc = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [wfe_pkg::LenW-1:0] limit_val,
                                     input int unsigned n_items);
    int unsigned target;
    set_limit(limit_val);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = live_items + n_items;
    while (live_items < target) send_random_frame();
    wait_idle();
    next_nc = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_beat = '{data: out_byte, has: has_byte, fend: frame_end, cls: close_now,
                   perr: protocol_error, lst: last};
      if (pending_echo.size() == 0) begin
        log_failure($sformatf("unexpected output transfer: %s", beat_str(got_beat)));
      end else begin
        want_beat = pending_echo.pop_front();
        if (got_beat !== want_beat)
          log_failure($sformatf("transfer %0d: expected %s, got %s", checked,
                                beat_str(want_beat), beat_str(got_beat)));
      end
      checked++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transfers still expected", cycle_count,
               pending_echo.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_masked_text();
    test_control_frames();
    test_short_ext16();
    test_ext64_at_limit();
    test_close_stops();
    test_length_limit();
    test_random_traffic(0, 0, wfe_pkg::MAX_LEN_RESET, 80);
    test_random_traffic(57, 0, wfe_pkg::LenW'($urandom_range(0, 40)), 80);
    test_random_traffic(0, 57, wfe_pkg::LenW'($urandom_range(100, 400)), 80);
    test_random_traffic(6, 6, wfe_pkg::LenW'($urandom_range(0, wfe_pkg::MAX_LEN_RESET)), 80);
    if (pending_echo.size() != 0)
      log_failure($sformatf("%0d expected transfers never arrived", pending_echo.size()));
    $display("Run covered %0d input bytes (%0d parsed) and %0d checked output transfers,",
             items_sent, live_items, checked);
    $display("over four sender/receiver idling mixes and %0d length-limit settings.",
             limit_writes);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fails);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
